>>> hdl/pfpm_pkg.sv
// package for the page frame pin manager: beat, frame entry and match types,
// kind, action and status codes, sequencer states; no dependencies
`timescale 1ns / 1ps

package pfpm_pkg;

	localparam int FRAMES_DEF = 16;
	localparam int KIND_W     = 3;
	localparam int FILE_W     = 10;
	localparam int PAGE_W     = 20;
	localparam int CNT_W      = 8;
	localparam int FRAME_W    = 4;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [KIND_W-1:0] K_PIN     = 3'd0;
	localparam logic [KIND_W-1:0] K_UNPIN   = 3'd1;
	localparam logic [KIND_W-1:0] K_RELEASE = 3'd2;
	localparam logic [KIND_W-1:0] K_WBACK   = 3'd3;
	localparam logic [KIND_W-1:0] K_CLOSE   = 3'd4;

	localparam logic [ACT_W-1:0] A_DONE  = 2'd0;
	localparam logic [ACT_W-1:0] A_READ  = 2'd1;
	localparam logic [ACT_W-1:0] A_WRITE = 2'd2;

	localparam logic [STAT_W-1:0] S_OK     = 2'd0;
	localparam logic [STAT_W-1:0] S_NOBUF  = 2'd1;
	localparam logic [STAT_W-1:0] S_NOTBUF = 2'd2;

	typedef struct packed {
		logic [FILE_W-1:0] file;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  count;
		logic              mapped;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic same_file;
	} match_t;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [FRAME_W-1:0] frame;
		logic [FILE_W-1:0]  file;
		logic [PAGE_W-1:0]  page;
		logic [STAT_W-1:0]  status;
		logic               last;
	} beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_WB,
		ST_DEC,
		ST_RDB
	} state_t;

endpackage

>>> hdl/pfpm_req_if.sv
// request channel of the page frame pin manager: valid, ready and request fields
// depends on pfpm_pkg for field widths
`timescale 1ns / 1ps

interface pfpm_req_if
	import pfpm_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [FILE_W-1:0] file_id;
	logic [PAGE_W-1:0] page_num;

	modport source (output valid, kind, file_id, page_num, input ready);
	modport sink (input valid, kind, file_id, page_num, output ready);
endinterface

>>> hdl/pfpm_rsp_if.sv
// result channel of the page frame pin manager: valid, ready and beat fields
// depends on pfpm_pkg for field widths
`timescale 1ns / 1ps

interface pfpm_rsp_if
	import pfpm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [FRAME_W-1:0] frame;
	logic [FILE_W-1:0]  out_file;
	logic [PAGE_W-1:0]  out_page;
	logic [STAT_W-1:0]  status;
	logic               last;

	modport source (output valid, action, frame, out_file, out_page, status, last, input ready);
	modport sink (input valid, action, frame, out_file, out_page, status, last, output ready);
endinterface

>>> hdl/pfpm_frame_store.sv
// frame table memory: one write port, one registered read port, per-frame valid bits
// depends on pfpm_pkg for the entry type
`timescale 1ns / 1ps

module pfpm_frame_store
	import pfpm_pkg::*;
#(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [$clog2(FRAMES)-1:0] rd_idx,
	output entry_t                    rd_data,
	input  logic                      wr_en,
	input  logic [$clog2(FRAMES)-1:0] wr_idx,
	input  entry_t                    wr_data
);
	entry_t            mem [FRAMES];
	logic [FRAMES-1:0] valid_q;
	entry_t            rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rdata_q <= mem[rd_idx];
		rvld_q  <= valid_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// entries never written read as the reset value
	assign rd_data = rvld_q ? rdata_q : '0;
endmodule

>>> hdl/pfpm_match_unit.sv
// shared compare unit: hit, free and same-file tests of one frame entry
// depends on pfpm_pkg for entry and match types
`timescale 1ns / 1ps

module pfpm_match_unit
	import pfpm_pkg::*;
(
	input  entry_t            ent,
	input  logic [FILE_W-1:0] file,
	input  logic [PAGE_W-1:0] page,
	output match_t            m
);
	logic file_eq;

	assign file_eq     = (ent.file == file);
	assign m.hit       = ent.mapped && file_eq && (ent.page == page);
	assign m.free      = (ent.count == '0);
	assign m.same_file = file_eq && (file != '0);
endmodule

>>> hdl/pfpm_seq.sv
// request sequencer: scans the frame table one entry per pass, updates it,
// and drives the result register; depends on pfpm_pkg and the channel interfaces
`timescale 1ns / 1ps

module pfpm_seq
	import pfpm_pkg::*;
#(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pfpm_req_if.sink                  req,
	pfpm_rsp_if.source                rsp,
	output logic [$clog2(FRAMES)-1:0] rd_idx,
	input  entry_t                    rd_data,
	input  match_t                    m,
	output logic [FILE_W-1:0]         file,
	output logic [PAGE_W-1:0]         page,
	output logic                      wr_en,
	output logic [$clog2(FRAMES)-1:0] wr_idx,
	output entry_t                    wr_data
);
	localparam int IDX_W = $clog2(FRAMES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAMES - 1);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [KIND_W-1:0] kind_q;
	logic [FILE_W-1:0] file_q;
	logic [PAGE_W-1:0] page_q;
	logic              hit_found_q, free_found_q;
	logic [IDX_W-1:0]  hit_idx_q, free_idx_q;
	entry_t            hit_ent_q, free_ent_q, cur_ent_q;
	logic              out_valid_q;
	beat_t             out_q;

	logic              accept, slot_free, is_close, at_last;
	logic              ld;
	beat_t             beat;
	logic [CNT_W-1:0]  dec_cnt;

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign is_close  = (kind_q == K_CLOSE);
	assign at_last   = (idx_q == IDX_LAST);
	assign dec_cnt   = (hit_ent_q.count == '0) ? hit_ent_q.count : hit_ent_q.count - 1'b1;

	assign req.ready = (state_q == ST_IDLE);
	assign rd_idx    = idx_q;
	assign file      = file_q;
	assign page      = page_q;

	assign rsp.valid    = out_valid_q;
	assign rsp.action   = out_q.action;
	assign rsp.frame    = out_q.frame;
	assign rsp.out_file = out_q.file;
	assign rsp.out_page = out_q.page;
	assign rsp.status   = out_q.status;
	assign rsp.last     = out_q.last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				priority if (is_close && m.same_file) begin
					state_d = ST_WB;
				end else if (at_last) begin
					state_d = ST_DEC;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_WB: begin
				if (slot_free) begin
					state_d = at_last ? ST_DEC : ST_RD;
				end
			end
			ST_DEC: begin
				if (slot_free) begin
					if (kind_q == K_PIN && !hit_found_q && free_found_q
						&& free_ent_q.file != '0) begin
						state_d = ST_RDB;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_RDB: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// beats and table writes
	always_comb begin
		ld      = 1'b0;
		beat    = '{action: A_DONE, frame: '0, file: file_q, page: page_q,
			status: S_OK, last: 1'b1};
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_data = rd_data;
		unique case (state_q)
			ST_CHK: begin
				if (is_close && m.same_file) begin
					wr_en          = 1'b1;
					wr_data.mapped = 1'b0;
				end
			end
			ST_WB: begin
				ld   = slot_free;
				beat = '{action: A_WRITE, frame: FRAME_W'(idx_q), file: cur_ent_q.file,
					page: cur_ent_q.page, status: S_OK, last: 1'b0};
			end
			ST_DEC: begin
				ld = slot_free;
				unique case (kind_q)
					K_PIN: begin
						priority if (hit_found_q) begin
							wr_en         = slot_free;
							wr_idx        = hit_idx_q;
							wr_data       = hit_ent_q;
							wr_data.count = (hit_ent_q.count == CNT_MAX) ? CNT_MAX
								: hit_ent_q.count + 1'b1;
							beat.frame    = FRAME_W'(hit_idx_q);
						end else if (!free_found_q) begin
							beat.status = S_NOBUF;
						end else begin
							wr_en   = slot_free;
							wr_idx  = free_idx_q;
							wr_data = '{file: file_q, page: page_q, count: CNT_W'(1),
								mapped: 1'b1};
							if (free_ent_q.file != '0) begin
								beat = '{action: A_WRITE, frame: FRAME_W'(free_idx_q),
									file: free_ent_q.file, page: free_ent_q.page,
									status: S_OK, last: 1'b0};
							end else begin
								beat.action = A_READ;
								beat.frame  = FRAME_W'(free_idx_q);
							end
						end
					end
					K_UNPIN, K_RELEASE: begin
						if (hit_found_q) begin
							wr_en          = slot_free;
							wr_idx         = hit_idx_q;
							wr_data        = hit_ent_q;
							wr_data.count  = dec_cnt;
							wr_data.mapped = !(kind_q == K_RELEASE && dec_cnt == '0);
							beat.frame     = FRAME_W'(hit_idx_q);
						end else begin
							beat.status = S_NOTBUF;
						end
					end
					K_WBACK: begin
						if (hit_found_q) begin
							beat = '{action: A_WRITE, frame: FRAME_W'(hit_idx_q),
								file: hit_ent_q.file, page: hit_ent_q.page,
								status: S_OK, last: 1'b1};
						end else begin
							beat.status = S_NOTBUF;
						end
					end
					default: begin
					end
				endcase
			end
			ST_RDB: begin
				ld          = slot_free;
				beat.action = A_READ;
				beat.frame  = FRAME_W'(free_idx_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q        <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (state_q == ST_CHK && !is_close) begin
				if (m.hit && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (m.free && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if ((state_q == ST_CHK && state_d == ST_RD)
				|| (state_q == ST_WB && state_d == ST_RD)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			file_q <= req.file_id;
			page_q <= req.page_num;
		end
		if (state_q == ST_CHK) begin
			cur_ent_q <= rd_data;
			if (!is_close && m.hit && !hit_found_q) begin
				hit_idx_q <= idx_q;
				hit_ent_q <= rd_data;
			end
			if (!is_close && m.free && !free_found_q) begin
				free_idx_q <= idx_q;
				free_ent_q <= rd_data;
			end
		end
		if (ld) begin
			out_q <= beat;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("frame index beyond table");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RD && idx_q == '0))
		else $error("request did not start a scan at frame zero");

	a_evict_write_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC && state_d == ST_RDB) |=>
		(out_valid_q && out_q.action == A_WRITE && !out_q.last))
		else $error("eviction read not preceded by write-back beat");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RD) |-> !wr_en)
		else $error("frame table written outside scan or decision");
endmodule

>>> hdl/page_frame_pin_manager_unit.sv
// Page frame pin manager, top level. Keeps a pool of FRAMES page frames
// (file, page, pin count, mapped flag) and serves pin, unpin, release,
// write-back and close-file requests.
// Channels: req (sink) takes one request beat {kind, file_id, page_num};
// rsp (source) gives result beats {action, frame, out_file, out_page,
// status, last}, last set on the final beat of each request.
// Each request walks the frame table through one shared compare unit, one
// entry at a time (memory read in ST_RD, then compare in ST_CHK), followed
// by the decision state ST_DEC; close file adds one ST_WB state per
// written-back frame, and an eviction adds the read state ST_RDB.
// req.ready is high only while no request is in progress.
// Results leave through an output register; a stalled rsp holds that beat
// and pauses the sequencer only when it has another beat to give.
// After reset all frames read as empty and unpinned; no clearing pass.
// Depends on pfpm_pkg, pfpm_req_if, pfpm_rsp_if and the submodules.
`timescale 1ns / 1ps

module page_frame_pin_manager_unit
	import pfpm_pkg::*;
#(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pfpm_req_if.sink   req,
	pfpm_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(FRAMES);

	logic [IDX_W-1:0]  rd_idx, wr_idx;
	entry_t            rd_data, wr_data;
	logic              wr_en;
	match_t            m;
	logic [FILE_W-1:0] file;
	logic [PAGE_W-1:0] page;

	pfpm_frame_store #(.FRAMES(FRAMES)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	pfpm_match_unit u_match (
		.ent  (rd_data),
		.file (file),
		.page (page),
		.m    (m)
	);

	pfpm_seq #(.FRAMES(FRAMES)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.m       (m),
		.file    (file),
		.page    (page),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);
endmodule
